>>> hw/rtl/i2crm_pkg.sv
// ----------------------------------------------------------------------------
// i2crm_pkg: shared types and codes of the i2c register transfer master
// item structs, request codes, sequencer phase and byte stage codes
// ----------------------------------------------------------------------------
package i2crm_pkg;

   // request codes
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   // sequencer phases
   localparam int unsigned PHASE_W = 5;
   localparam logic [PHASE_W-1:0] PH_IDLE      = 5'd0;
   localparam logic [PHASE_W-1:0] PH_ST_SDA_HI = 5'd1;
   localparam logic [PHASE_W-1:0] PH_ST_SCL_HI = 5'd2;
   localparam logic [PHASE_W-1:0] PH_ST_SDA_LO = 5'd3;
   localparam logic [PHASE_W-1:0] PH_ST_SCL_LO = 5'd4;
   localparam logic [PHASE_W-1:0] PH_WB_SET    = 5'd5;
   localparam logic [PHASE_W-1:0] PH_WB_HI     = 5'd6;
   localparam logic [PHASE_W-1:0] PH_WB_LO     = 5'd7;
   localparam logic [PHASE_W-1:0] PH_WA_REL    = 5'd8;
   localparam logic [PHASE_W-1:0] PH_WA_HI     = 5'd9;
   localparam logic [PHASE_W-1:0] PH_WA_LO     = 5'd10;
   localparam logic [PHASE_W-1:0] PH_WB_LOAD   = 5'd11;
   localparam logic [PHASE_W-1:0] PH_RB_REL    = 5'd12;
   localparam logic [PHASE_W-1:0] PH_RB_HI     = 5'd13;
   localparam logic [PHASE_W-1:0] PH_RB_LO     = 5'd14;
   localparam logic [PHASE_W-1:0] PH_MA_SET    = 5'd15;
   localparam logic [PHASE_W-1:0] PH_MA_HI     = 5'd16;
   localparam logic [PHASE_W-1:0] PH_MA_LO     = 5'd17;
   localparam logic [PHASE_W-1:0] PH_SP_SDA_LO = 5'd18;
   localparam logic [PHASE_W-1:0] PH_SP_SCL_HI = 5'd19;
   localparam logic [PHASE_W-1:0] PH_SP_SDA_HI = 5'd20;

   // byte stages
   localparam logic [1:0] STG_ADDR_W = 2'd0;
   localparam logic [1:0] STG_REG    = 2'd1;
   localparam logic [1:0] STG_DATA   = 2'd2;
   localparam logic [1:0] STG_ADDR_R = 2'd3;

   localparam logic [2:0] LAST_BIT = 3'd7;

   typedef struct packed {
      logic [1:0] req_type;
      logic [6:0] slave_addr;
      logic [7:0] reg_addr;
      logic [7:0] length;
      logic [7:0] tx_byte;
      logic       sda_in;
   } req_item_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_listen;
      logic [7:0] rx_byte;
      logic       rx_valid;
      logic       want_byte;
      logic       busy_res;
      logic       done_res;
      logic       status;
   } rsp_item_type;

endpackage

>>> hw/rtl/i2c_register_transfer_master_top.sv
// ----------------------------------------------------------------------------
// i2c_register_transfer_master_top: i2c master for register reads and writes
// input register, one-step bus sequencer, result register
// ----------------------------------------------------------------------------
// usage: send a begin item (write or read) carrying slave address, register
// address and byte count, then one tick item per bus step with the sampled
// sda level; every item, begin or tick, returns exactly one result item with
// the driven scl/sda levels and status flags. a write takes each data byte
// from tx_byte on the tick that follows a result with want_byte set; a read
// delivers each byte with rx_valid, acks all but the last and nacks the last.
// any nack from the device ends the transaction with a stop and status 1 on
// the done item. a begin while busy, or an unknown request code, is dropped
// and just returns the current line levels. timing: one item per clock
// while results are taken; an item lands in the input register at the edge
// that accepts it and its result is loaded into the result register as the
// item leaves the input register, once the result register is free. the
// sequencer state advances as an item leaves the input register, so items
// follow each other back to back. while a result waits to be taken the
// input register still takes one more item, then req_stall stays high until
// the waiting result moves on
// ----------------------------------------------------------------------------
module i2c_register_transfer_master_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  i2crm_pkg::req_item_type req_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output i2crm_pkg::rsp_item_type rsp_item
);
   import i2crm_pkg::*;

   logic         held_valid;
   req_item_type held_item;
   rsp_item_type step_result;
   logic         out_free;
   logic         fire;

   // an item steps the sequencer only when the result register can take it
   assign fire = held_valid && out_free;

   // input register
   i2crm_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .take       (fire),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   // bus sequencer, one line change per tick item
   i2crm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (held_item),
      .result (step_result)
   );

   // result register
   i2crm_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .result    (step_result),
      .free      (out_free),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

>>> hw/rtl/i2crm_in_stage.sv
// ----------------------------------------------------------------------------
// i2crm_in_stage: input register
// holds one request item until the sequencer takes it
// ----------------------------------------------------------------------------
module i2crm_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  i2crm_pkg::req_item_type req_item,
   input  logic                   take,
   output logic                   held_valid,
   output i2crm_pkg::req_item_type held_item
);
   import i2crm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // refill when empty or when the held item moves on
   assign load      = !valid_ff || take;
   assign req_stall = !load;
   assign valid_in  = load ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

>>> hw/rtl/i2crm_core.sv
// ----------------------------------------------------------------------------
// i2crm_core: bus sequencer
// transaction state and the one line-change step taken per item
// ----------------------------------------------------------------------------
module i2crm_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  i2crm_pkg::req_item_type item,
   output i2crm_pkg::rsp_item_type result
);
   import i2crm_pkg::*;

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [2:0]         bit_count_ff, bit_count_in;
   logic [7:0]         shift_reg_ff, shift_reg_in;
   logic [7:0]         byte_count_ff, byte_count_in;
   logic [7:0]         txn_length_ff, txn_length_in;
   logic [6:0]         target_addr_ff, target_addr_in;
   logic [7:0]         register_addr_ff, register_addr_in;
   logic               is_read_ff, is_read_in;
   logic               line_scl_ff, line_scl_in;
   logic               line_sda_ff, line_sda_in;
   logic [1:0]         stage_ff, stage_in;
   logic               err_ff, err_in;

   logic [7:0] byte_count_inc;
   logic [7:0] rx_shift;
   logic       listen, rxv, want, done, stat;
   logic [7:0] rx;

   assign byte_count_inc = byte_count_ff + 8'd1;
   assign rx_shift       = {shift_reg_ff[6:0], item.sda_in};

   always_comb begin
      phase_in         = phase_ff;
      bit_count_in     = bit_count_ff;
      shift_reg_in     = shift_reg_ff;
      byte_count_in    = byte_count_ff;
      txn_length_in    = txn_length_ff;
      target_addr_in   = target_addr_ff;
      register_addr_in = register_addr_ff;
      is_read_in       = is_read_ff;
      line_scl_in      = line_scl_ff;
      line_sda_in      = line_sda_ff;
      stage_in         = stage_ff;
      err_in           = err_ff;
      listen = 1'b0;
      rxv    = 1'b0;
      want   = 1'b0;
      done   = 1'b0;
      stat   = 1'b0;
      rx     = 8'd0;

      if (item.req_type != REQ_TICK) begin
         // begin only from idle, anything else is dropped
         if ((item.req_type == REQ_WRITE || item.req_type == REQ_READ)
             && phase_ff == PH_IDLE) begin
            target_addr_in   = item.slave_addr;
            register_addr_in = item.reg_addr;
            txn_length_in    = item.length;
            is_read_in       = (item.req_type == REQ_READ);
            byte_count_in    = 8'd0;
            bit_count_in     = 3'd0;
            stage_in         = STG_ADDR_W;
            err_in           = 1'b0;
            phase_in         = PH_ST_SDA_HI;
         end
      end else begin
         unique case (phase_ff)
            PH_ST_SDA_HI: begin line_sda_in = 1'b1; phase_in = PH_ST_SCL_HI; end
            PH_ST_SCL_HI: begin line_scl_in = 1'b1; phase_in = PH_ST_SDA_LO; end
            PH_ST_SDA_LO: begin line_sda_in = 1'b0; phase_in = PH_ST_SCL_LO; end
            PH_ST_SCL_LO: begin
               line_scl_in  = 1'b0;
               shift_reg_in = {target_addr_ff, stage_ff == STG_ADDR_R};
               bit_count_in = 3'd0;
               phase_in     = PH_WB_SET;
            end
            PH_WB_SET: begin
               line_sda_in = shift_reg_ff[7];
               phase_in    = PH_WB_HI;
            end
            PH_WB_HI: begin line_scl_in = 1'b1; phase_in = PH_WB_LO; end
            PH_WB_LO: begin
               line_scl_in  = 1'b0;
               shift_reg_in = {shift_reg_ff[6:0], 1'b0};
               if (bit_count_ff == LAST_BIT) begin
                  bit_count_in = 3'd0;
                  phase_in     = PH_WA_REL;
               end else begin
                  bit_count_in = bit_count_ff + 3'd1;
                  phase_in     = PH_WB_SET;
               end
            end
            PH_WA_REL: begin line_sda_in = 1'b1; listen = 1'b1; phase_in = PH_WA_HI; end
            PH_WA_HI:  begin line_scl_in = 1'b1; listen = 1'b1; phase_in = PH_WA_LO; end
            PH_WA_LO: begin
               line_scl_in = 1'b0;
               listen      = 1'b1;
               if (item.sda_in) begin
                  // not acknowledged: straight to stop
                  err_in   = 1'b1;
                  phase_in = PH_SP_SDA_LO;
               end else begin
                  unique case (stage_ff)
                     STG_ADDR_W: begin
                        stage_in     = STG_REG;
                        shift_reg_in = register_addr_ff;
                        bit_count_in = 3'd0;
                        phase_in     = PH_WB_SET;
                     end
                     STG_REG: begin
                        if (is_read_ff) begin
                           stage_in = STG_ADDR_R;
                           phase_in = PH_ST_SDA_HI;
                        end else if (txn_length_ff == 8'd0) begin
                           phase_in = PH_SP_SDA_LO;
                        end else begin
                           stage_in = STG_DATA;
                           want     = 1'b1;
                           phase_in = PH_WB_LOAD;
                        end
                     end
                     STG_DATA: begin
                        byte_count_in = byte_count_inc;
                        if (byte_count_inc == txn_length_ff) begin
                           phase_in = PH_SP_SDA_LO;
                        end else begin
                           want     = 1'b1;
                           phase_in = PH_WB_LOAD;
                        end
                     end
                     STG_ADDR_R: begin
                        phase_in = (txn_length_ff == 8'd0) ? PH_SP_SDA_LO : PH_RB_REL;
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
            PH_WB_LOAD: begin
               shift_reg_in = item.tx_byte;
               bit_count_in = 3'd0;
               line_sda_in  = item.tx_byte[7];
               phase_in     = PH_WB_HI;
            end
            PH_RB_REL: begin
               line_sda_in  = 1'b1;
               listen       = 1'b1;
               shift_reg_in = 8'd0;
               bit_count_in = 3'd0;
               phase_in     = PH_RB_HI;
            end
            PH_RB_HI: begin line_scl_in = 1'b1; listen = 1'b1; phase_in = PH_RB_LO; end
            PH_RB_LO: begin
               line_scl_in  = 1'b0;
               listen       = 1'b1;
               shift_reg_in = rx_shift;
               if (bit_count_ff == LAST_BIT) begin
                  rx            = rx_shift;
                  rxv           = 1'b1;
                  byte_count_in = byte_count_inc;
                  bit_count_in  = 3'd0;
                  phase_in      = PH_MA_SET;
               end else begin
                  bit_count_in = bit_count_ff + 3'd1;
                  phase_in     = PH_RB_HI;
               end
            end
            PH_MA_SET: begin
               // nack after the last byte, ack otherwise
               line_sda_in = (byte_count_ff == txn_length_ff);
               phase_in    = PH_MA_HI;
            end
            PH_MA_HI: begin line_scl_in = 1'b1; phase_in = PH_MA_LO; end
            PH_MA_LO: begin
               line_scl_in = 1'b0;
               phase_in    = (byte_count_ff == txn_length_ff) ? PH_SP_SDA_LO : PH_RB_REL;
            end
            PH_SP_SDA_LO: begin line_sda_in = 1'b0; phase_in = PH_SP_SCL_HI; end
            PH_SP_SCL_HI: begin line_scl_in = 1'b1; phase_in = PH_SP_SDA_HI; end
            PH_SP_SDA_HI: begin
               line_sda_in = 1'b1;
               done        = 1'b1;
               stat        = err_ff;
               phase_in    = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_comb begin
      result.scl        = line_scl_in;
      result.sda_out    = line_sda_in;
      result.sda_listen = listen;
      result.rx_byte    = rx;
      result.rx_valid   = rxv;
      result.want_byte  = want;
      result.busy_res   = (phase_in != PH_IDLE);
      result.done_res   = done;
      result.status     = stat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         bit_count_ff     <= 3'd0;
         shift_reg_ff     <= 8'd0;
         byte_count_ff    <= 8'd0;
         txn_length_ff    <= 8'd0;
         target_addr_ff   <= 7'd0;
         register_addr_ff <= 8'd0;
         is_read_ff       <= 1'b0;
         line_scl_ff      <= 1'b1;
         line_sda_ff      <= 1'b1;
         stage_ff         <= STG_ADDR_W;
         err_ff           <= 1'b0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         bit_count_ff     <= bit_count_in;
         shift_reg_ff     <= shift_reg_in;
         byte_count_ff    <= byte_count_in;
         txn_length_ff    <= txn_length_in;
         target_addr_ff   <= target_addr_in;
         register_addr_ff <= register_addr_in;
         is_read_ff       <= is_read_in;
         line_scl_ff      <= line_scl_in;
         line_sda_ff      <= line_sda_in;
         stage_ff         <= stage_in;
         err_ff           <= err_in;
      end
   end

endmodule

>>> hw/rtl/i2crm_out_stage.sv
// ----------------------------------------------------------------------------
// i2crm_out_stage: result register
// holds one result item until downstream takes it
// ----------------------------------------------------------------------------
module i2crm_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  i2crm_pkg::rsp_item_type result,
   output logic                    free,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output i2crm_pkg::rsp_item_type rsp_item
);
   import i2crm_pkg::*;

   logic         valid_ff, valid_in;
   rsp_item_type item_ff;

   // free when empty or being taken this cycle
   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

>>> hw/rtl/i2crm_checker.sv
// ----------------------------------------------------------------------------
// i2crm_checker: port-level checks of the i2c register transfer master
// result flags that must agree with each other, stalled result hold
// ----------------------------------------------------------------------------
module i2crm_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input i2crm_pkg::rsp_item_type rsp_item
);
   import i2crm_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("stalled result item changed");

   // done closes the transaction
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.done_res |-> !rsp_item.busy_res && rsp_item.scl
         && rsp_item.sda_out)
      else $error("done without bus released");

   // status only on the done item
   a_status_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status |-> rsp_item.done_res)
      else $error("status outside done");

   // a received byte completes while sampling with scl low
   a_rx_listen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.rx_valid |-> rsp_item.sda_listen && !rsp_item.scl
         && rsp_item.busy_res)
      else $error("received byte outside sampling");

   // byte request only mid transaction with scl low
   a_want_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.want_byte |-> rsp_item.busy_res && !rsp_item.scl
         && !rsp_item.rx_valid)
      else $error("byte request outside write");

endmodule

bind i2c_register_transfer_master_top i2crm_checker u_i2crm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the i2c register transfer master
// drives begin and tick items, models the device side on sda_in, predicts the
// line levels and flags of every result item and checks them field by field
// ----------------------------------------------------------------------------
module tb;
   import i2crm_pkg::*;

   // request code that the block must drop
   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   localparam int IDLE_PCT      = 34;
   localparam int HOLD_CYCLES   = 120;
   localparam int STALL_LIMIT   = 2000;
   localparam int TOTAL_ITEMS   = 1050;
   localparam int NO_IDLE_ITEMS = 150;
   localparam int MAX_REPORTS   = 40;

   // device answer modes for write data and read bits
   localparam int DATA_RANDOM = 0;
   localparam int DATA_ONES   = 1;
   localparam int DATA_ZEROS  = 2;
   localparam int DATA_ALT    = 3;

   // no forced nack
   localparam int ACK_ALL = -1;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   // shared stimulus controls, written with nonblocking assignments
   logic no_idling   = 1'b0;
   int   hold_ticket = 0;

   int mismatches   = 0;
   int results_seen = 0;
   int items_sent   = 0;

   // line levels and flags predicted for items already accepted
   rsp_item_type pending_lines[$];

   // predicted sequencer state
   logic [PHASE_W-1:0] seq_phase;
   logic [2:0]         seq_bits;
   logic [7:0]         seq_shift;
   logic [7:0]         seq_count;
   logic [7:0]         seq_len;
   logic [6:0]         seq_target;
   logic [7:0]         seq_regaddr;
   logic               seq_read;
   logic [1:0]         seq_stage;
   logic               seq_nacked;
   logic               bus_scl;
   logic               bus_sda;

   i2c_register_transfer_master_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // prediction: one bus step per accepted item
   // ------------------------------------------------------------------
   task automatic advance_bus(input req_item_type it, output rsp_item_type r);
      r = '0;
      if (it.req_type != REQ_TICK) begin
         // a begin only counts while idle, an unknown code never does
         if ((it.req_type == REQ_WRITE || it.req_type == REQ_READ) &&
             seq_phase == PH_IDLE) begin
            seq_target  = it.slave_addr;
            seq_regaddr = it.reg_addr;
            seq_len     = it.length;
            seq_read    = (it.req_type == REQ_READ);
            seq_count   = '0;
            seq_bits    = '0;
            seq_stage   = STG_ADDR_W;
            seq_nacked  = 1'b0;
            seq_phase   = PH_ST_SDA_HI;
         end
      end else begin
         case (seq_phase)
            // start or repeated start
            PH_ST_SDA_HI: begin bus_sda = 1'b1; seq_phase = PH_ST_SCL_HI; end
            PH_ST_SCL_HI: begin bus_scl = 1'b1; seq_phase = PH_ST_SDA_LO; end
            PH_ST_SDA_LO: begin bus_sda = 1'b0; seq_phase = PH_ST_SCL_LO; end
            PH_ST_SCL_LO: begin
               bus_scl   = 1'b0;
               seq_shift = {seq_target, seq_stage == STG_ADDR_R};
               seq_bits  = '0;
               seq_phase = PH_WB_SET;
            end
            // byte out, msb first
            PH_WB_SET: begin bus_sda = seq_shift[7]; seq_phase = PH_WB_HI; end
            PH_WB_HI:  begin bus_scl = 1'b1; seq_phase = PH_WB_LO; end
            PH_WB_LO: begin
               bus_scl   = 1'b0;
               seq_shift = seq_shift << 1;
               if (seq_bits == LAST_BIT) begin
                  seq_bits  = '0;
                  seq_phase = PH_WA_REL;
               end else begin
                  seq_bits  = seq_bits + 3'd1;
                  seq_phase = PH_WB_SET;
               end
            end
            // device acknowledge
            PH_WA_REL: begin
               bus_sda = 1'b1; r.sda_listen = 1'b1; seq_phase = PH_WA_HI;
            end
            PH_WA_HI: begin
               bus_scl = 1'b1; r.sda_listen = 1'b1; seq_phase = PH_WA_LO;
            end
            PH_WA_LO: begin
               bus_scl      = 1'b0;
               r.sda_listen = 1'b1;
               if (it.sda_in) begin
                  seq_nacked = 1'b1;
                  seq_phase  = PH_SP_SDA_LO;
               end else begin
                  case (seq_stage)
                     STG_ADDR_W: begin
                        seq_stage = STG_REG;
                        seq_shift = seq_regaddr;
                        seq_bits  = '0;
                        seq_phase = PH_WB_SET;
                     end
                     STG_REG: begin
                        if (seq_read) begin
                           seq_stage = STG_ADDR_R;
                           seq_phase = PH_ST_SDA_HI;
                        end else if (seq_len == 8'd0) begin
                           seq_phase = PH_SP_SDA_LO;
                        end else begin
                           seq_stage   = STG_DATA;
                           r.want_byte = 1'b1;
                           seq_phase   = PH_WB_LOAD;
                        end
                     end
                     STG_DATA: begin
                        seq_count = seq_count + 8'd1;
                        if (seq_count == seq_len) begin
                           seq_phase = PH_SP_SDA_LO;
                        end else begin
                           r.want_byte = 1'b1;
                           seq_phase   = PH_WB_LOAD;
                        end
                     end
                     default: begin
                        seq_phase = (seq_len == 8'd0) ? PH_SP_SDA_LO : PH_RB_REL;
                     end
                  endcase
               end
            end
            PH_WB_LOAD: begin
               seq_shift = it.tx_byte;
               seq_bits  = '0;
               bus_sda   = seq_shift[7];
               seq_phase = PH_WB_HI;
            end
            // byte in
            PH_RB_REL: begin
               bus_sda      = 1'b1;
               r.sda_listen = 1'b1;
               seq_shift    = '0;
               seq_bits     = '0;
               seq_phase    = PH_RB_HI;
            end
            PH_RB_HI: begin
               bus_scl = 1'b1; r.sda_listen = 1'b1; seq_phase = PH_RB_LO;
            end
            PH_RB_LO: begin
               bus_scl      = 1'b0;
               r.sda_listen = 1'b1;
               seq_shift    = {seq_shift[6:0], it.sda_in};
               if (seq_bits == LAST_BIT) begin
                  r.rx_byte  = seq_shift;
                  r.rx_valid = 1'b1;
                  seq_count  = seq_count + 8'd1;
                  seq_bits   = '0;
                  seq_phase  = PH_MA_SET;
               end else begin
                  seq_bits  = seq_bits + 3'd1;
                  seq_phase = PH_RB_HI;
               end
            end
            // master ack, nack after the last byte
            PH_MA_SET: begin
               bus_sda   = (seq_count == seq_len);
               seq_phase = PH_MA_HI;
            end
            PH_MA_HI: begin bus_scl = 1'b1; seq_phase = PH_MA_LO; end
            PH_MA_LO: begin
               bus_scl   = 1'b0;
               seq_phase = (seq_count == seq_len) ? PH_SP_SDA_LO : PH_RB_REL;
            end
            // stop
            PH_SP_SDA_LO: begin bus_sda = 1'b0; seq_phase = PH_SP_SCL_HI; end
            PH_SP_SCL_HI: begin bus_scl = 1'b1; seq_phase = PH_SP_SDA_HI; end
            PH_SP_SDA_HI: begin
               bus_sda    = 1'b1;
               r.done_res = 1'b1;
               r.status   = seq_nacked;
               seq_phase  = PH_IDLE;
            end
            default: seq_phase = PH_IDLE;
         endcase
      end
      r.scl      = bus_scl;
      r.sda_out  = bus_sda;
      r.busy_res = (seq_phase != PH_IDLE);
   endtask

   // ------------------------------------------------------------------
   // input side
   // ------------------------------------------------------------------
   function automatic req_item_type random_item();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(req_item_type)-1:0];
   endfunction

   // byte pattern the device side uses for write data and read data
   function automatic logic [7:0] pattern_byte(input int mode, input logic [7:0] idx);
      case (mode)
         DATA_ONES:  return 8'hFF;
         DATA_ZEROS: return 8'h00;
         DATA_ALT:   return idx[0] ? 8'h5A : 8'hA5;
         default:    return 8'($urandom);
      endcase
   endfunction

   // offer one item, hold it until taken, then predict its result
   task automatic send_item(input req_item_type it);
      rsp_item_type want;
      while (!no_idling && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      advance_bus(it, want);
      pending_lines.push_back(want);
   endtask

   // stop offering and wait for every predicted result to be taken
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
   endtask

   // one whole transaction: begin item, then ticks until the stop completes;
   // sda_in answers like a device, with an optional nack at ack number nack_at
   task automatic run_transfer(input logic [1:0] kind, input logic [6:0] addr,
                               input logic [7:0] regn, input logic [7:0] len,
                               input int nack_at, input int nack_pct,
                               input int noise_pct, input int mode);
      req_item_type it;
      int           ack_no;
      logic [7:0]   data;
      it            = random_item();
      it.req_type   = kind;
      it.slave_addr = addr;
      it.reg_addr   = regn;
      it.length     = len;
      send_item(it);
      ack_no = 0;
      while (seq_phase != PH_IDLE) begin
         // begin or unknown code while busy, to be dropped
         if ($urandom_range(99) < noise_pct) begin
            it = random_item();
            case ($urandom_range(2))
               0:       it.req_type = REQ_WRITE;
               1:       it.req_type = REQ_READ;
               default: it.req_type = REQ_UNKNOWN;
            endcase
            send_item(it);
         end
         it          = random_item();
         it.req_type = REQ_TICK;
         data        = pattern_byte(mode, seq_count);
         case (seq_phase)
            PH_WA_LO: begin
               it.sda_in = (ack_no == nack_at) || ($urandom_range(99) < nack_pct);
               ack_no++;
            end
            PH_RB_LO:   it.sda_in  = data[3'd7 - seq_bits];
            PH_WB_LOAD: it.tx_byte = data;
            default: ;
         endcase
         send_item(it);
      end
   endtask

   // ------------------------------------------------------------------
   // result side: check each taken item, then choose the next stall
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("tb: result %0d: %s", results_seen, msg);
   endtask

   task automatic check_lines(input rsp_item_type got);
      rsp_item_type want;
      if (pending_lines.size() == 0) begin
         report_mismatch("result item with nothing predicted");
         return;
      end
      want = pending_lines.pop_front();
      if (got.scl !== want.scl)
         report_mismatch($sformatf("scl %0b, want %0b", got.scl, want.scl));
      if (got.sda_out !== want.sda_out)
         report_mismatch($sformatf("sda_out %0b, want %0b", got.sda_out, want.sda_out));
      if (got.sda_listen !== want.sda_listen)
         report_mismatch($sformatf("sda_listen %0b, want %0b",
                                   got.sda_listen, want.sda_listen));
      if (got.rx_byte !== want.rx_byte)
         report_mismatch($sformatf("rx_byte %02h, want %02h", got.rx_byte, want.rx_byte));
      if (got.rx_valid !== want.rx_valid)
         report_mismatch($sformatf("rx_valid %0b, want %0b", got.rx_valid, want.rx_valid));
      if (got.want_byte !== want.want_byte)
         report_mismatch($sformatf("want_byte %0b, want %0b",
                                   got.want_byte, want.want_byte));
      if (got.busy_res !== want.busy_res)
         report_mismatch($sformatf("busy_res %0b, want %0b", got.busy_res, want.busy_res));
      if (got.done_res !== want.done_res)
         report_mismatch($sformatf("done_res %0b, want %0b", got.done_res, want.done_res));
      if (got.status !== want.status)
         report_mismatch($sformatf("status %0b, want %0b", got.status, want.status));
   endtask

   initial begin : result_side
      int hold_left;
      int seen_ticket;
      hold_left   = 0;
      seen_ticket = 0;
      forever begin
         @(posedge clock);
         // values read here are the ones the block saw at this edge
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            check_lines(rsp_item);
         end
         // a new ticket starts a long hold-off counted here
         if (hold_ticket != seen_ticket) begin
            seen_ticket = hold_ticket;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idling && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // cycles with no item moving on either side end the run
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb: no item moved for %0d cycles", STALL_LIMIT);
      $display("tb: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // ticks and an unknown code while idle, fields at both extremes
   task automatic test_idle_requests();
      req_item_type it;
      it = '0;
      send_item(it);
      it          = '1;
      it.req_type = REQ_TICK;
      send_item(it);
      it = '1;
      send_item(it);
      it          = '0;
      it.req_type = REQ_UNKNOWN;
      send_item(it);
   endtask

   // writes: zero length, then two bytes alternating between A5 and 5A
   task automatic test_write_paths();
      run_transfer(REQ_WRITE, 7'h7F, 8'hFF, 8'd0, ACK_ALL, 0, 0, DATA_ONES);
      run_transfer(REQ_WRITE, 7'h00, 8'h00, 8'd2, ACK_ALL, 0, 0, DATA_ALT);
   endtask

   // reads: zero length stops after address+r, then two bytes
   task automatic test_read_paths();
      run_transfer(REQ_READ, 7'h00, 8'h00, 8'd0, ACK_ALL, 0, 0, DATA_RANDOM);
      run_transfer(REQ_READ, 7'h7F, 8'hFF, 8'd2, ACK_ALL, 0, 0, DATA_ALT);
   endtask

   // nack on the address, on a data byte and on address+r; longest length
   // so that only the nack ends it
   task automatic test_nack_paths();
      run_transfer(REQ_WRITE, 7'h7F, 8'h12, 8'd255, 0, 0, 0, DATA_RANDOM);
      run_transfer(REQ_WRITE, 7'h40, 8'h7F, 8'd255, 2, 0, 0, DATA_ALT);
      run_transfer(REQ_READ,  7'h3C, 8'h01, 8'd255, 2, 0, 0, DATA_RANDOM);
   endtask

   // begins and unknown codes mixed in while a transaction runs
   task automatic test_ignored_begins();
      run_transfer(REQ_WRITE, 7'h11, 8'h22, 8'd0, ACK_ALL, 0, 40, DATA_RANDOM);
   endtask

   // result side holds off while items keep coming, then the sender waits
   // for every result before going on
   task automatic test_backpressure();
      hold_ticket <= hold_ticket + 1;
      run_transfer(REQ_WRITE, 7'h5D, 8'h9C, 8'd1, ACK_ALL, 0, 10, DATA_RANDOM);
      drain_results();
   endtask

   // random transactions, mostly short and well formed
   task automatic test_random();
      req_item_type it;
      int           first;
      int           pick;
      int           nack_at;
      int           mode;
      logic [7:0]   len;
      first = items_sent;
      while (items_sent < TOTAL_ITEMS) begin
         // a long stretch with no idling on either side
         no_idling <= (items_sent - first < NO_IDLE_ITEMS);
         // a few ticks while idle
         repeat ($urandom_range(2)) begin
            it          = random_item();
            it.req_type = REQ_TICK;
            send_item(it);
         end
         pick    = $urandom_range(99);
         nack_at = ACK_ALL;
         if (pick < 70) begin
            len = 8'($urandom_range(2));
         end else if (pick < 92) begin
            len = 8'($urandom_range(6, 3));
         end else begin
            // long lengths end early on a nack to bound the run
            len     = 8'($urandom_range(255, 7));
            nack_at = $urandom_range(2);
         end
         mode = ($urandom_range(3) == 0) ? $urandom_range(DATA_ALT, DATA_ONES) : DATA_RANDOM;
         run_transfer(($urandom_range(1) != 0) ? REQ_READ : REQ_WRITE,
                      7'($urandom), 8'($urandom), len, nack_at, 2, 5, mode);
      end
      no_idling <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // sequence of the run
   // ------------------------------------------------------------------
   initial begin
      // predicted state after reset, bus idle high
      seq_phase   = PH_IDLE;
      seq_bits    = '0;
      seq_shift   = '0;
      seq_count   = '0;
      seq_len     = '0;
      seq_target  = '0;
      seq_regaddr = '0;
      seq_read    = 1'b0;
      seq_stage   = STG_ADDR_W;
      seq_nacked  = 1'b0;
      bus_scl     = 1'b1;
      bus_sda     = 1'b1;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_idle_requests();
      test_write_paths();
      test_read_paths();
      test_nack_paths();
      test_ignored_begins();
      test_backpressure();
      test_random();

      // all stimulus taken: wait for the last results, then a little longer
      // so that a stray extra result would still be caught
      drain_results();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
